@@ rtl/tsp_pkg.sv @@
`default_nettype none
package tsp_pkg;

  localparam int unsigned POSITION_BITS_DEF       = 32;
  localparam int unsigned SPEED_FRACTION_BITS_DEF = 8;

  localparam int unsigned POS_PORT_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned DIST_W      = 20;
  localparam int unsigned SPEED_OUT_W = 15;
  localparam int unsigned OUT_DATA_W  = 24;

  localparam int unsigned MIN_SPEED_PCT = 5;
  localparam int unsigned MIN_SPAN      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN   = 3'd4;

  localparam logic KIND_START = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRAV,
    ST_EVAL,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic trav;
    logic eval;
    logic div_start;
    logic div_sel_d;
    logic cap_qa;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/tsp_div.sv @@
`default_nettype none
module tsp_div import tsp_pkg::*; #(
  parameter int unsigned QW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [QW+DIST_W-1:0] num_i,
  input  wire logic [DIST_W-1:0]    den_i,
  output logic                      busy_o,
  output logic [QW-1:0]             quot_o
);

  localparam int unsigned CW = $clog2(QW);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [DIST_W-1:0] r_q;
  logic [DIST_W-1:0] d_q;
  logic [QW-1:0]     n_q;

  logic [DIST_W:0]   trial;
  logic [DIST_W:0]   diff;
  logic              ge;

  assign trial = {r_q, n_q[QW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit a cycle shifted in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= num_i[QW+DIST_W-1:QW];
      n_q <= num_i[QW-1:0];
      d_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
      n_q <= {n_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = n_q;

endmodule
`default_nettype wire

@@ rtl/tsp_datapath.sv @@
`default_nettype none
module tsp_datapath import tsp_pkg::*; #(
  parameter int unsigned POSITION_BITS       = POSITION_BITS_DEF,
  parameter int unsigned SPEED_FRACTION_BITS = SPEED_FRACTION_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_kind_i,
  input  wire logic [POS_PORT_W-1:0] in_left_i,
  input  wire logic [POS_PORT_W-1:0] in_right_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned F  = SPEED_FRACTION_BITS;
  localparam int unsigned QW = 7 + F;
  localparam int unsigned AW = P + 5;
  localparam int unsigned VMIN_INT = MIN_SPEED_PCT << F;
  localparam logic [QW-1:0] VMIN = QW'(VMIN_INT);

  // configuration
  logic [16:0] tgt_q;
  logic [6:0]  vmax_pct_q;
  logic [15:0] acc_q;
  logic [15:0] dec_q;
  logic        turn_q;

  logic [P-1:0] start_l_q, start_r_q;
  logic         done_q;
  logic [P-1:0] pos_l_q, pos_r_q;
  logic [P+1:0] travel_q;
  logic [DIST_W-1:0] avg_q, rem_q, a16_q, d16_q;
  logic         la_q, ld_q;
  logic [QW-1:0] qa_q;
  logic         out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  function automatic logic [DIST_W-1:0] times_k(input logic [16:0] x, input logic turn);
    logic [DIST_W-1:0] ext;
    ext = DIST_W'(x);
    return turn ? (ext << 2) + ext : (ext << 4) - ext;
  endfunction

  function automatic logic [P:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] d;
    d = {a[P-1], a} - {b[P-1], b};
    return d[P] ? (~d + (P+1)'(1)) : d;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      vmax_pct_q <= '0;
      acc_q      <= 16'(MIN_SPAN);
      dec_q      <= 16'(MIN_SPAN);
      turn_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: tgt_q      <= cfg_data_i;
        CFG_VMAX:   vmax_pct_q <= cfg_data_i[6:0];
        CFG_ACCEL:  acc_q      <= cfg_data_i[15:0];
        CFG_DECEL:  dec_q      <= cfg_data_i[15:0];
        CFG_TURN:   turn_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // target and ramp spans in 1/16 tick
  logic              neg;
  logic [16:0]       mag;
  logic [16:0]       acc_eff, dec_eff;
  logic [DIST_W-1:0] t16, a16, d16, avg_lo, rem;
  logic [AW-1:0]     avg_full;
  logic              hit;

  assign neg      = tgt_q[16];
  assign mag      = neg ? (17'h0 - tgt_q) : tgt_q;
  assign acc_eff  = (acc_q < 16'(MIN_SPAN)) ? 17'(MIN_SPAN) : {1'b0, acc_q};
  assign dec_eff  = (dec_q < 16'(MIN_SPAN)) ? 17'(MIN_SPAN) : {1'b0, dec_q};
  assign t16      = times_k(mag, turn_q);
  assign a16      = times_k(acc_eff, turn_q);
  assign d16      = times_k(dec_eff, turn_q);
  assign avg_full = {travel_q, 3'b000};
  assign hit      = avg_full >= AW'(t16);
  assign avg_lo   = avg_full[DIST_W-1:0];
  assign rem      = t16 - avg_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_l_q <= '0;
      start_r_q <= '0;
      done_q    <= 1'b0;
    end else if (cmd_i.load && in_kind_i == KIND_START) begin
      start_l_q <= in_left_i[P-1:0];
      start_r_q <= in_right_i[P-1:0];
      done_q    <= 1'b0;
    end else if (cmd_i.eval && hit) begin
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_l_q <= in_left_i[P-1:0];
      pos_r_q <= in_right_i[P-1:0];
    end
    if (cmd_i.trav) begin
      travel_q <= {1'b0, abs_diff(pos_l_q, start_l_q)} + {1'b0, abs_diff(pos_r_q, start_r_q)};
    end
    if (cmd_i.eval) begin
      avg_q <= avg_lo;
      rem_q <= rem;
      a16_q <= a16;
      d16_q <= d16;
      la_q  <= avg_lo < a16;
      ld_q  <= rem < d16;
    end
  end

  // one shared multiplier feeds the divider for both ramps
  logic [QW-1:0]        vmax;
  logic [DIST_W-1:0]    mul_b;
  logic [QW+DIST_W-1:0] num;
  logic [DIST_W-1:0]    den;
  logic                 div_busy;
  logic [QW-1:0]        quot;

  assign vmax  = {vmax_pct_q, F'(0)};
  assign mul_b = cmd_i.div_sel_d ? rem_q : avg_q;
  assign num   = (QW+DIST_W)'(vmax) * (QW+DIST_W)'(mul_b);
  assign den   = cmd_i.div_sel_d ? d16_q : a16_q;

  tsp_div #(
    .QW (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_qa) begin
      qa_q <= quot;
    end
  end

  // speed select and floor
  logic [QW-1:0]          spd_a, spd_b, spd;
  logic [QW+SPEED_OUT_W-1:0] spd_ext;
  logic                   lf, rf;
  logic [OUT_DATA_W-1:0]  res;

  assign spd_a   = la_q ? qa_q : vmax;
  assign spd_b   = (ld_q && quot < spd_a) ? quot : spd_a;
  assign spd     = (spd_b < VMIN) ? VMIN : spd_b;
  assign spd_ext = {SPEED_OUT_W'(0), spd};
  assign lf      = ~neg;
  assign rf      = turn_q ? neg : ~neg;
  assign res     = done_q ? {6'b0, 1'b1, 1'b0, 1'b0, SPEED_OUT_W'(0)}
                          : {6'b0, 1'b0, rf, lf, spd_ext[SPEED_OUT_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign sts_o.done     = done_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule
`default_nettype wire

@@ rtl/tsp_ctrl.sv @@
`default_nettype none
module tsp_ctrl import tsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TRAV;
        end
      end
      ST_TRAV: begin
        cmd_o.trav = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_DIVA_GO;
      end
      ST_DIVA_GO: begin
        // done result needs no ramps
        if (sts_i.done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVA_WAIT;
        end
      end
      ST_DIVA_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.cap_qa = 1'b1;
          state_d      = ST_DIVD_GO;
        end
      end
      ST_DIVD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_d = 1'b1;
        state_d         = ST_DIVD_WAIT;
      end
      ST_DIVD_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/trapezoidal_speed_profiler.sv @@
`default_nettype none
// latency: set by the two passes of the bit-serial ramp divider from request accept to result;
//   a done move skips both divider passes
// throughput: one request at a time, next accepted once the result is in the output register
// output register lets a new request be accepted while the previous result waits
// reset: asynchronous active low; clears reference positions, done flag and configuration, ramp spans to MIN_SPAN
module trapezoidal_speed_profiler import tsp_pkg::*; #(
  parameter int unsigned POSITION_BITS       = POSITION_BITS_DEF,
  parameter int unsigned SPEED_FRACTION_BITS = SPEED_FRACTION_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // left_position [31:0], right_position [63:32]
  input  wire logic [63:0]           s_axis_tdata,
  // kind
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // speed_command [14:0], left_forward [15], right_forward [16], move_done [17]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  tsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsp_datapath #(
    .POSITION_BITS       (POSITION_BITS),
    .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (s_axis_tuser),
    .in_left_i   (s_axis_tdata[31:0]),
    .in_right_i  (s_axis_tdata[63:32]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
